// File: src/assert_macros.svh
// assertion macros for the hopscotch bucket locator
// used by modules that carry concurrent checks; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define HBL_ASSERT_IMP(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under an active-low reset
`define HBL_ASSERT_NXT(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/hbl_pkg.sv
// shared types and codes for the hopscotch bucket locator
// no dependencies; imported by the interface users, sequencer and top level
package hbl_pkg;

    // request functions
    localparam logic FN_LOCATE = 1'b0;
    localparam logic FN_WRITE  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_LOG2   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBORHOOD_SIZE = 1'd1;

    // configuration reset values
    localparam logic [3:0] TSL_RESET = 4'd8;
    localparam logic [8:0] NHS_RESET = 9'd32;

    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_FULL       = 3'd2,
        ST_GROW_TABLE = 3'd3,
        ST_GROW_NH    = 3'd4,
        ST_WRITTEN    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_HOP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_NEIGH,
        PH_FIND,
        PH_HOP
    } t_phase;

    typedef struct packed {
        logic        func;
        logic [63:0] key;
        logic [31:0] key_hash;
        logic [7:0]  target_bucket;
        logic [31:0] entry_value;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  bucket_index;
    } t_rsp;

    // memory port strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_cmd;

endpackage

// File: src/hbl_stream_if.sv
// valid/ready channel carrying one payload type
// payload types come from hbl_pkg at the instance
interface hbl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/hopscotch_bucket_locator.sv
// top level of the hopscotch bucket locator: config registers, bucket stores,
// occupancy bits and the response register; depends on hbl_pkg, hbl_stream_if,
// hbl_ram, hbl_seq and assert_macros.svh
//
// usage: requests arrive on i_req (valid/ready), one response per request
// leaves on o_rsp (valid/ready). func locate searches the key's neighborhood,
// then the rest of the table for an empty bucket, then hops it back toward
// the home bucket; func write stores hash, key and value at a bucket.
// throughput: one request at a time; i_req.ready is high only while the
// sequencer is idle. every bucket visit is a read, then a compare in the
// shared unit, on the single read port of the stores, and each hop round
// adds a hop step. a write goes from idle straight to the done state; a
// locate reads and compares every bucket that it visits along its walk.
// the response sits in an output register, so the sequencer goes idle as
// soon as the register has room; a stalled receiver holds the response and
// the next one waits in the sequencer.
// reset (synchronous, active low) clears all occupancy bits, so every bucket
// reads empty at once with no clearing pass, and loads table_size_log2 = 8,
// neighborhood_size = 32. config writes are taken at any edge with i_cfg_we.
`include "assert_macros.svh"

module hopscotch_bucket_locator
    import hbl_pkg::*;
#(
    parameter int BUCKETS    = 256,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32,
    parameter int HASH_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hbl_stream_if.sink            i_req,
    hbl_stream_if.source          o_rsp
);
    localparam int MAX_LG = $clog2(BUCKETS + 1) - 1;
    localparam int IW     = (MAX_LG > 8) ? 8 : MAX_LG;
    localparam int DEPTH  = 1 << IW;

    logic [3:0] r_tsl;
    logic [8:0] r_nhs;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsl <= TSL_RESET;
            r_nhs <= NHS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TABLE_SIZE_LOG2:   r_tsl <= i_cfg_data[3:0];
                CFG_NEIGHBORHOOD_SIZE: r_nhs <= i_cfg_data;
                default:               r_tsl <= r_tsl;
            endcase
        end
    end

    t_mem_cmd              w_cmd;
    logic [IW-1:0]         w_rd_addr, w_wr_addr;
    logic [HASH_BITS-1:0]  w_wr_hash, w_hash_q, w_rd_hash;
    logic [KEY_BITS-1:0]   w_wr_key, w_key_q;
    logic [VALUE_BITS-1:0] w_wr_val, w_val_q;
    logic                  w_idle, w_start, w_res_vld, w_take;
    t_rsp                  w_res;

    assign i_req.ready = w_idle;
    assign w_start     = i_req.valid && w_idle;

    hbl_seq #(
        .IW         (IW),
        .HASH_BITS  (HASH_BITS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_req     (i_req.payload),
        .i_tsl     (r_tsl),
        .i_nhs     (r_nhs),
        .i_rd_hash (w_rd_hash),
        .i_rd_key  (w_key_q),
        .i_rd_val  (w_val_q),
        .i_take    (w_take),
        .o_idle    (w_idle),
        .o_cmd     (w_cmd),
        .o_rd_addr (w_rd_addr),
        .o_wr_addr (w_wr_addr),
        .o_wr_hash (w_wr_hash),
        .o_wr_key  (w_wr_key),
        .o_wr_val  (w_wr_val),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    // bucket stores
    hbl_ram #(.WIDTH(HASH_BITS), .DEPTH(DEPTH)) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (w_cmd.wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_hash),
        .i_re    (w_cmd.rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_hash_q)
    );

    hbl_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_cmd.wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_key),
        .i_re    (w_cmd.rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_key_q)
    );

    hbl_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_cmd.wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_val),
        .i_re    (w_cmd.rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_val_q)
    );

    // occupancy bits: a bucket never written reads as hash zero
    logic [DEPTH-1:0] r_vld;
    logic             r_hvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_cmd.wr_en) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.rd_en) begin
            r_hvld <= r_vld[w_rd_addr];
        end
    end

    assign w_rd_hash = r_hvld ? w_hash_q : '0;

    // response register
    logic r_ovld;
    t_rsp r_orsp;

    assign w_take = !r_ovld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_take) begin
            r_ovld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_vld) begin
            r_orsp <= w_res;
        end
    end

    assign o_rsp.valid   = r_ovld;
    assign o_rsp.payload = r_orsp;

    // checks
    `HBL_ASSERT_IMP(a_no_rw_overlap, i_clk, i_rst_n, w_cmd.wr_en, !w_cmd.rd_en)
    `HBL_ASSERT_NXT(a_wr_marks_bucket, i_clk, i_rst_n, w_cmd.wr_en, r_vld[$past(w_wr_addr)])
    `HBL_ASSERT_NXT(a_res_lands, i_clk, i_rst_n, w_res_vld && w_take, r_ovld)
    `HBL_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, w_res_vld, !i_req.ready)
endmodule

// File: src/hbl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module hbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/hbl_seq.sv
// sequencer and shared compare unit of the hopscotch bucket locator
// depends on hbl_pkg; drives the bucket stores through the top level
module hbl_seq
    import hbl_pkg::*;
#(
    parameter int IW         = 8,
    parameter int HASH_BITS  = 32,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_req                  i_req,
    input  logic [3:0]            i_tsl,
    input  logic [8:0]            i_nhs,
    input  logic [HASH_BITS-1:0]  i_rd_hash,
    input  logic [KEY_BITS-1:0]   i_rd_key,
    input  logic [VALUE_BITS-1:0] i_rd_val,
    input  logic                  i_take,
    output logic                  o_idle,
    output t_mem_cmd              o_cmd,
    output logic [IW-1:0]         o_rd_addr,
    output logic [IW-1:0]         o_wr_addr,
    output logic [HASH_BITS-1:0]  o_wr_hash,
    output logic [KEY_BITS-1:0]   o_wr_key,
    output logic [VALUE_BITS-1:0] o_wr_val,
    output logic                  o_res_vld,
    output t_rsp                  o_res
);
    localparam int CW = IW + 1;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [IW-1:0]         r_mask, n_mask;
    logic [CW-1:0]         r_size, n_size;
    logic [CW-1:0]         r_nh, n_nh;
    logic [IW-1:0]         r_begin, n_begin;
    logic [IW-1:0]         r_base, n_base;
    logic [IW-1:0]         r_addr, n_addr;
    logic [IW-1:0]         r_e, n_e;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_lim, n_lim;
    logic [CW-1:0]         r_guard, n_guard;
    logic [CW-1:0]         r_coll, n_coll;
    logic [HASH_BITS-1:0]  r_sample, n_sample;
    logic [HASH_BITS-1:0]  r_hash, n_hash;
    logic [KEY_BITS-1:0]   r_key, n_key;
    t_status               r_status, n_status;
    logic [IW-1:0]         r_bucket, n_bucket;

    // configuration decode at request time
    logic [3:0]    w_lg;
    logic [CW-1:0] w_size;
    logic [IW-1:0] w_mask;
    logic [CW-1:0] w_nh;
    logic          w_wr_req;
    logic [IW-1:0] w_tgt;

    always_comb begin
        if (i_tsl == 4'd0) begin
            w_lg = 4'd1;
        end else if (i_tsl > 4'(IW)) begin
            w_lg = 4'(IW);
        end else begin
            w_lg = i_tsl;
        end
    end

    assign w_size = CW'(1) << w_lg;
    assign w_mask = IW'(w_size - CW'(1));

    always_comb begin
        if (i_nhs == 9'd0) begin
            w_nh = CW'(1);
        end else if (i_nhs > 9'(w_size)) begin
            w_nh = w_size;
        end else begin
            w_nh = CW'(i_nhs);
        end
    end

    assign w_wr_req = i_start && (i_req.func == FN_WRITE);
    assign w_tgt    = IW'(i_req.target_bucket) & w_mask;

    // shared compare unit on the bucket just read
    logic          w_hz, w_match, w_last, w_movable, w_cont, w_hit_sample;
    logic [CW-1:0] w_cnt1, w_coll1, w_back, w_span;
    logic [HASH_BITS-1:0] w_sample;
    logic [IW-1:0] w_home, w_dist, w_gap, w_end, w_hop_base, w_rd_addr;

    assign w_hz         = (i_rd_hash == '0);
    assign w_match      = (i_rd_hash == r_hash) && (i_rd_key == r_key);
    assign w_cnt1       = r_cnt + CW'(1);
    assign w_last       = (w_cnt1 == r_lim);
    assign w_sample     = (r_cnt == '0) ? i_rd_hash : r_sample;
    assign w_hit_sample = (i_rd_hash == w_sample);
    assign w_coll1      = r_coll + CW'(w_hit_sample);
    assign w_home       = IW'(i_rd_hash) & r_mask;
    assign w_dist       = (r_e - w_home) & r_mask;
    assign w_movable    = !w_hz && (CW'(w_dist) < r_nh);
    assign w_gap        = (r_e - r_begin) & r_mask;
    assign w_cont       = (r_guard <= r_size) && (CW'(w_gap) >= r_nh);
    assign w_back       = r_nh - CW'(1);
    assign w_hop_base   = (r_e - IW'(w_back)) & r_mask;
    assign w_end        = (r_begin + IW'(r_nh)) & r_mask;
    assign w_span       = (r_nh == r_size) ? r_size : (r_size - r_nh);
    assign w_rd_addr    = (r_base + IW'(r_cnt)) & r_mask;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_req.func == FN_WRITE) ? S_DONE : S_READ;
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                case (r_phase)
                    PH_NEIGH: n_state = (w_hz || w_match) ? S_DONE : S_READ;
                    PH_FIND: begin
                        if (w_hz) begin
                            n_state = S_HOP;
                        end else begin
                            n_state = w_last ? S_DONE : S_READ;
                        end
                    end
                    PH_HOP: begin
                        if (w_movable) begin
                            n_state = S_HOP;
                        end else begin
                            n_state = w_last ? S_DONE : S_READ;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_HOP: begin
                if (w_cont && w_back != '0) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs toward the stores and the result slot
    always_comb begin
        o_cmd     = '0;
        o_rd_addr = w_rd_addr;
        o_wr_addr = r_e;
        o_wr_hash = i_rd_hash;
        o_wr_key  = i_rd_key;
        o_wr_val  = i_rd_val;
        case (r_state)
            S_IDLE: begin
                if (w_wr_req) begin
                    o_cmd.wr_en = 1'b1;
                    o_wr_addr   = w_tgt;
                    o_wr_hash   = HASH_BITS'(i_req.key_hash);
                    o_wr_key    = KEY_BITS'(i_req.key);
                    o_wr_val    = VALUE_BITS'(i_req.entry_value);
                end
            end
            S_READ: o_cmd.rd_en = 1'b1;
            S_CHECK: o_cmd.wr_en = (r_phase == PH_HOP) && w_movable;
            default: o_cmd = '0;
        endcase
    end

    assign o_idle             = (r_state == S_IDLE);
    assign o_res_vld          = (r_state == S_DONE);
    assign o_res.status       = r_status;
    assign o_res.bucket_index = 8'(r_bucket);

    // working registers
    always_comb begin
        n_phase  = r_phase;
        n_mask   = r_mask;
        n_size   = r_size;
        n_nh     = r_nh;
        n_begin  = r_begin;
        n_base   = r_base;
        n_addr   = r_addr;
        n_e      = r_e;
        n_cnt    = r_cnt;
        n_lim    = r_lim;
        n_guard  = r_guard;
        n_coll   = r_coll;
        n_sample = r_sample;
        n_hash   = r_hash;
        n_key    = r_key;
        n_status = r_status;
        n_bucket = r_bucket;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mask   = w_mask;
                    n_size   = w_size;
                    n_nh     = w_nh;
                    n_begin  = IW'(i_req.key_hash) & w_mask;
                    n_base   = IW'(i_req.key_hash) & w_mask;
                    n_cnt    = '0;
                    n_lim    = w_nh;
                    n_phase  = PH_NEIGH;
                    n_hash   = HASH_BITS'(i_req.key_hash);
                    n_key    = KEY_BITS'(i_req.key);
                    n_status = ST_WRITTEN;
                    n_bucket = w_tgt;
                end
            end
            S_READ: n_addr = w_rd_addr;
            S_CHECK: begin
                n_cnt = w_cnt1;
                case (r_phase)
                    PH_NEIGH: begin
                        if (w_hz) begin
                            n_status = ST_EMPTY;
                            n_bucket = r_addr;
                        end else if (w_match) begin
                            n_status = ST_FOUND;
                            n_bucket = r_addr;
                        end else if (w_last) begin
                            n_phase = PH_FIND;
                            n_base  = w_end;
                            n_cnt   = '0;
                            n_lim   = w_span;
                        end
                    end
                    PH_FIND: begin
                        if (w_hz) begin
                            n_e     = r_addr;
                            n_guard = '0;
                        end else if (w_last) begin
                            n_status = ST_FULL;
                            n_bucket = '0;
                        end
                    end
                    PH_HOP: begin
                        n_sample = w_sample;
                        n_coll   = w_coll1;
                        if (w_movable) begin
                            n_e     = r_addr;
                            n_guard = r_guard + CW'(1);
                        end else if (w_last) begin
                            n_status = (w_coll1 < r_lim) ? ST_GROW_TABLE : ST_GROW_NH;
                            n_bucket = '0;
                        end
                    end
                    default: n_phase = PH_NEIGH;
                endcase
            end
            S_HOP: begin
                if (!w_cont) begin
                    n_status = ST_EMPTY;
                    n_bucket = r_e;
                end else if (w_back == '0) begin
                    n_status = ST_GROW_NH;
                    n_bucket = '0;
                end else begin
                    n_phase = PH_HOP;
                    n_base  = w_hop_base;
                    n_cnt   = '0;
                    n_lim   = w_back;
                    n_coll  = '0;
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_NEIGH;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mask   <= n_mask;
        r_size   <= n_size;
        r_nh     <= n_nh;
        r_begin  <= n_begin;
        r_base   <= n_base;
        r_addr   <= n_addr;
        r_e      <= n_e;
        r_cnt    <= n_cnt;
        r_lim    <= n_lim;
        r_guard  <= n_guard;
        r_coll   <= n_coll;
        r_sample <= n_sample;
        r_hash   <= n_hash;
        r_key    <= n_key;
        r_status <= n_status;
        r_bucket <= n_bucket;
    end
endmodule
